[sv/assert_macros.svh]
// Assertion macros shared by the chorus core modules.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/scd_pkg.sv]
// Shared types, constants and the sine table function of the chorus core.
// No dependencies; imported by the controller, the datapath and the top level.
package scd_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int MAXD_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int SINE_W     = 16;
    localparam int MAG_W      = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_MIX  = 4'd3;

    localparam logic [GAIN_W-1:0] WET_GAIN_RESET = 16'h8000;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] K1 = 64'd1686629713;
    localparam logic [63:0] K3 = 64'd693598668;
    localparam logic [63:0] K5 = 64'd85569306;
    localparam logic [63:0] K7 = 64'd5026994;
    localparam logic [63:0] K9 = 64'd172273;

    typedef struct packed {
        logic load;
        logic calc_delay;
        logic read;
        logic mult;
        logic finish;
    } scd_cmd_t;

    typedef struct packed {
        logic out_free;
    } scd_status_t;

    // Q0.15 magnitude of sin(pi/2 * m / 2^qbits), odd degree-9 polynomial in Q30.
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned m, input int unsigned qbits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] v;
        t  = 64'(m) << (30 - qbits);
        t2 = (t * t) >> 30;
        p  = K9;
        p  = K7 - ((t2 * p) >> 30);
        p  = K5 - ((t2 * p) >> 30);
        p  = K3 - ((t2 * p) >> 30);
        p  = K1 - ((t2 * p) >> 30);
        v  = (t * p) >> 30;
        v  = (v + (64'd1 << 14)) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

[sv/scd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds one delay line of the chorus core.
module scd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/scd_ctrl.sv]
// Frame sequencer of the chorus core: accept, delay, read, multiply, finish.
// Depends on scd_pkg for the command and status structs.
`include "assert_macros.svh"

module scd_ctrl import scd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  scd_status_t status,
    output scd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DLY,
        ST_RD,
        ST_MUL,
        ST_SUM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_ready        = (state_reg == ST_IDLE) || ((state_reg == ST_SUM) && status.out_free);
        cmd.load       = s_valid && s_ready;
        cmd.calc_delay = (state_reg == ST_DLY);
        cmd.read       = (state_reg == ST_RD);
        cmd.mult       = (state_reg == ST_MUL);
        cmd.finish     = (state_reg == ST_SUM) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_DLY;
                end
            end
            ST_DLY: state_next = ST_RD;
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = ST_SUM;
            ST_SUM: begin
                if (status.out_free) begin
                    state_next = cmd.load ? ST_DLY : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SCD_ASSERT_NEXT(a_load_starts, cmd.load, state_reg == ST_DLY, "accepted word did not start")
    `SCD_ASSERT_NEXT(a_stall_holds, (state_reg == ST_SUM) && !status.out_free, state_reg == ST_SUM, "left finish while output full")

endmodule

[sv/scd_datapath.sv]
// Datapath of the chorus core: registers, LFO, sine table, delay lines and mixer.
// Depends on scd_pkg and scd_ram; driven by commands from scd_ctrl.
`include "assert_macros.svh"

module scd_datapath import scd_pkg::*; #(
    parameter int DELAY_DEPTH     = 4096,
    parameter int SINE_TABLE_SIZE = 1024,
    parameter int PHASE_BITS      = 24,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scd_cmd_t                      cmd,
    output scd_status_t                   status,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int LN      = $clog2(SINE_TABLE_SIZE);
    localparam int QW      = LN - 2;
    localparam int QUARTER = SINE_TABLE_SIZE / 4;
    localparam int PW      = PHASE_BITS + LN;
    localparam int DP_W    = MAXD_W + SINE_W + 1;
    localparam int XS_W    = SAMPLE_BITS + 18;
    localparam int P_W     = SAMPLE_BITS + 33;
    localparam int N_W     = SAMPLE_BITS + 35;
    localparam int Q_W     = N_W - 31;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    logic [MAXD_W-1:0]     max_delay_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [GAIN_W-1:0]     wet_gain_reg;
    logic [GAIN_W-1:0]     send_mix_reg;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [AW-1:0]         wp_reg;
    logic                  wrapped_reg;
    logic signed [SAMPLE_BITS-1:0] x_l_reg;
    logic signed [SAMPLE_BITS-1:0] x_r_reg;
    logic signed [SINE_W-1:0]      sine_reg;
    logic [AW-1:0]                 dly_reg;
    logic signed [XS_W-1:0]        xs_l_reg;
    logic signed [XS_W-1:0]        xs_r_reg;
    logic [2*GAIN_W-1:0]           sg_reg;
    logic                          hit_reg;
    logic signed [P_W-1:0]         p_l_reg;
    logic signed [P_W-1:0]         p_r_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_left_reg;
    logic signed [SAMPLE_BITS-1:0] m_right_reg;

    logic [MAG_W-1:0] sine_tab [QUARTER+1];

    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sine
        localparam logic [MAG_W-1:0] MAG = sine_mag(gi, QW);
        assign sine_tab[gi] = MAG;
    end

    logic [PW-1:0]     phase_ext;
    logic [LN-1:0]     sine_idx;
    logic [1:0]        quad;
    logic [QW:0]       qaddr;
    logic [MAG_W-1:0]  mag;
    logic signed [SINE_W-1:0] sine_next;
    logic [AW-1:0]     wp_next;

    always_comb begin
        phase_ext = {phase_reg, {LN{1'b0}}};
        sine_idx  = phase_ext[PW-1 -: LN];
        quad      = sine_idx[LN-1 -: 2];
        qaddr     = quad[0] ? ((QW+1)'(QUARTER) - {1'b0, sine_idx[QW-1:0]})
                            : {1'b0, sine_idx[QW-1:0]};
        mag       = sine_tab[qaddr];
        sine_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        wp_next   = wp_reg + 1'b1;
    end

    logic [SINE_W-1:0]      sine_off;
    logic [DP_W-1:0]        d_full;
    logic [AW-1:0]          dly_next;
    logic [GAIN_W:0]        dry;
    logic signed [XS_W-1:0] xs_l_next;
    logic signed [XS_W-1:0] xs_r_next;
    logic [2*GAIN_W-1:0]    sg_next;

    always_comb begin
        sine_off  = {~sine_reg[SINE_W-1], sine_reg[SINE_W-2:0]};
        d_full    = DP_W'(max_delay_reg) * DP_W'(sine_off) + (DP_W'(1) << (SINE_W - 1));
        dly_next  = AW'(d_full >> SINE_W);
        dry       = (GAIN_W+1)'(1 << GAIN_W) - {1'b0, send_mix_reg};
        xs_l_next = XS_W'(x_l_reg) * XS_W'($signed({1'b0, dry}));
        xs_r_next = XS_W'(x_r_reg) * XS_W'($signed({1'b0, dry}));
        sg_next   = (2*GAIN_W)'(send_mix_reg) * (2*GAIN_W)'(wet_gain_reg);
    end

    logic [SAMPLE_BITS-1:0]        rdata_l;
    logic [SAMPLE_BITS-1:0]        rdata_r;
    logic [AW-1:0]                 raddr;
    logic signed [SAMPLE_BITS-1:0] y_l;
    logic signed [SAMPLE_BITS-1:0] y_r;
    logic signed [P_W-1:0]         p_l_next;
    logic signed [P_W-1:0]         p_r_next;

    always_comb begin
        raddr    = wp_reg - dly_reg;
        y_l      = hit_reg ? $signed(rdata_l) : '0;
        y_r      = hit_reg ? $signed(rdata_r) : '0;
        p_l_next = P_W'($signed({1'b0, sg_reg})) * P_W'(y_l);
        p_r_next = P_W'($signed({1'b0, sg_reg})) * P_W'(y_r);
    end

    scd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_left_line (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (wp_next),
        .wdata (s_left_in),
        .re    (cmd.read),
        .raddr (raddr),
        .rdata (rdata_l)
    );

    scd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_right_line (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (wp_next),
        .wdata (s_right_in),
        .re    (cmd.read),
        .raddr (raddr),
        .rdata (rdata_r)
    );

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic signed [Q_W-1:0] q);
        logic signed [Q_W-1:0] c;
        c = q;
        if (q > Q_MAX) begin
            c = Q_MAX;
        end else if (q < Q_MIN) begin
            c = Q_MIN;
        end
        return SAMPLE_BITS'(c);
    endfunction

    logic signed [N_W-1:0]         num_l;
    logic signed [N_W-1:0]         num_r;
    logic signed [SAMPLE_BITS-1:0] out_l_next;
    logic signed [SAMPLE_BITS-1:0] out_r_next;

    always_comb begin
        num_l      = (N_W'(xs_l_reg) <<< 15) + N_W'(p_l_reg) + (N_W'(1) << 30);
        num_r      = (N_W'(xs_r_reg) <<< 15) + N_W'(p_r_reg) + (N_W'(1) << 30);
        out_l_next = saturate(Q_W'(num_l >>> 31));
        out_r_next = saturate(Q_W'(num_r >>> 31));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_delay_reg  <= '0;
            phase_step_reg <= '0;
            wet_gain_reg   <= WET_GAIN_RESET;
            send_mix_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_DELAY:  max_delay_reg  <= cfg_data[MAXD_W-1:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                CFG_WET_GAIN:   wet_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_SEND_MIX:   send_mix_reg   <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                phase_reg   <= phase_reg + phase_step_reg;
                wp_reg      <= wp_next;
                wrapped_reg <= wrapped_reg || (wp_next == '0);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_l_reg  <= s_left_in;
            x_r_reg  <= s_right_in;
            sine_reg <= sine_next;
        end
        if (cmd.calc_delay) begin
            dly_reg  <= dly_next;
            xs_l_reg <= xs_l_next;
            xs_r_reg <= xs_r_next;
            sg_reg   <= sg_next;
        end
        if (cmd.read) begin
            hit_reg <= wrapped_reg || (dly_reg < wp_reg);
        end
        if (cmd.mult) begin
            p_l_reg <= p_l_next;
            p_r_reg <= p_r_next;
        end
        if (cmd.finish) begin
            m_left_reg  <= out_l_next;
            m_right_reg <= out_r_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_left_out      = m_left_reg;
    assign m_right_out     = m_right_reg;

    `SCD_ASSERT_NEXT(a_wrap_sticks, wrapped_reg, wrapped_reg, "wrap flag cleared outside reset")
    `SCD_ASSERT_NEXT(a_ptr_advance, cmd.load, wp_reg == $past(wp_reg) + 1'b1, "write pointer did not advance")
    `SCD_ASSERT_NEXT(a_finish_shows, cmd.finish, m_valid, "finished frame not presented")

endmodule

[sv/stereo_chorus_delay_core.sv]
// Stereo chorus: LFO-modulated delay with wet/dry crossfade.
// Usage: s_valid/s_ready take one stereo word (s_left_in, s_right_in); m_valid/m_ready
// return one stereo word (m_left_out, m_right_out) per input word, in order.
// cfg_valid/cfg_ready write cfg_data into the register at cfg_index (0 max delay,
// 1 phase step, 2 wet gain, 3 send mix); write only while no word is in flight.
// m_valid rises when the finish step completes, which waits while the output is full.
// Words are handled one at a time by the sequence sine lookup and delay
// multiply, delay-line read, wet product, round and saturate, all through one
// datapath with one read port per delay line, so the next word waits for the finish.
// Reset (aresetn low, synchronous): write pointer, LFO phase and registers return to
// their defaults; delay-line entries not yet written since reset read as zero, tracked
// by the write pointer and a wrap flag, so no clearing pass is needed.
// Receiver stall: the finished word holds in the output register; the next input word
// is still accepted and processed, and the core waits at the final step until the
// output register frees.
// Depends on scd_pkg, scd_ctrl, scd_datapath and scd_ram.
module stereo_chorus_delay_core import scd_pkg::*; #(
    parameter int DELAY_DEPTH     = 4096,
    parameter int SINE_TABLE_SIZE = 1024,
    parameter int PHASE_BITS      = 24,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    scd_cmd_t    cmd;
    scd_status_t status;

    assign cfg_ready = 1'b1;

    scd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scd_datapath #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
        .PHASE_BITS      (PHASE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule

[verif/tb_stereo_chorus_delay_core.sv]
// Self-checking bench for stereo_chorus_delay_core: a directed table, then random
// stereo words under random sender gaps and receiver stalls, checked by a chorus predictor.
// Depends on scd_pkg and the core RTL.
module tb_stereo_chorus_delay_core import scd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH   = 4096;
    localparam int SINE_SIZE    = 1024;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SEG_WORDS    = 115;
    localparam int DIR_ROWS     = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_word_t;

    typedef enum bit {ROW_FRAME, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic signed [15:0]    left;
        logic signed [15:0]    right;
        bit                    lit;
        stereo_word_t          want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [15:0]    s_left_in = '0;
    logic signed [15:0]    s_right_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [15:0]    m_left_out;
    logic signed [15:0]    m_right_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // chorus state and registers as the core should hold them
    logic [11:0]        max_delay;
    logic [23:0]        phase_step;
    logic [15:0]        wet_gain;
    logic [15:0]        send_mix;
    logic [11:0]        wr_ptr;
    logic [23:0]        lfo_phase;
    logic signed [15:0] left_line [LINE_DEPTH];
    logic signed [15:0] right_line [LINE_DEPTH];
    int                 sine_tbl [SINE_SIZE];

    stereo_word_t expected_words[$];

    int send_gap_pct = 37;
    int recv_stall_pct = 60;
    int words_sent = 0;
    int words_checked = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_FRAME, '0, '0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0}},
        '{ROW_FRAME, '0, '0, 16'sd32767, -16'sd32768, 1'b1, '{16'sd32767, -16'sd32768}},
        '{ROW_FRAME, '0, '0, -16'sd1, 16'sd1, 1'b1, '{-16'sd1, 16'sd1}},
        '{ROW_FRAME, '0, '0, 16'sh5555, 16'shAAAA, 1'b1, '{16'sh5555, 16'shAAAA}},
        '{ROW_CFG, CFG_SEND_MIX, 32'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd1000, -16'sd1000, 1'b1, '{16'sd1000, -16'sd1000}},
        '{ROW_FRAME, '0, '0, -16'sd32768, 16'sd32767, 1'b1, '{-16'sd32768, 16'sd32767}},
        '{ROW_CFG, CFG_WET_GAIN, 32'h0000_FFFF, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd32767, -16'sd32768, 1'b1, '{16'sd32767, -16'sd32768}},
        '{ROW_CFG, CFG_WET_GAIN, 32'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_SEND_MIX, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
        '{ROW_FRAME, '0, '0, -16'sd12345, 16'sd23456, 1'b0, '0},
        '{ROW_CFG, CFG_SEND_MIX, 32'h0000_4000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WET_GAIN, 32'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_MAX_DELAY, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PHASE_STEP, 32'hFF40_0000, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd100, -16'sd100, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd200, -16'sd200, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd300, -16'sd300, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd400, -16'sd400, 1'b0, '0},
        '{ROW_FRAME, '0, '0, -16'sd32768, 16'sd32767, 1'b0, '0},
        '{ROW_CFG, CFG_FIRST_UNUSED, 32'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_LAST_UNUSED, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd500, -16'sd500, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
        '{ROW_CFG, CFG_MAX_DELAY, 32'h0000_0003, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PHASE_STEP, 32'h00FF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd7, -16'sd7, 1'b0, '0},
        '{ROW_FRAME, '0, '0, 16'sd8, -16'sd8, 1'b0, '0},
        '{ROW_FRAME, '0, '0, -16'sd9, 16'sd9, 1'b0, '0}
    };

    stereo_chorus_delay_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_left_in  (s_left_in),
        .s_right_in (s_right_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_left_out (m_left_out),
        .m_right_out(m_right_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [15:0] mix_sample(input logic signed [15:0] x,
                                                      input logic signed [15:0] y);
        longint sx, sy, sm, g, num, q;
        sx = x;
        sy = y;
        sm = send_mix;
        g = wet_gain;
        num = sx * (32768 - sm) * 65536 + sm * (sx * 32768 + g * sy);
        q = (num + (longint'(1) << 30)) >>> 31;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    function automatic void chorus_predict(input logic signed [15:0] xl,
                                           input logic signed [15:0] xr,
                                           output stereo_word_t res);
        longint      s, d;
        logic [11:0] rd;
        wr_ptr = wr_ptr + 12'd1;
        left_line[wr_ptr] = xl;
        right_line[wr_ptr] = xr;
        s = sine_tbl[lfo_phase[23:14]];
        d = ((longint'(max_delay) * (32768 + s) + 32768) >>> 16) % LINE_DEPTH;
        rd = wr_ptr - d[11:0];
        res.left = mix_sample(xl, left_line[rd]);
        res.right = mix_sample(xr, right_line[rd]);
        lfo_phase = lfo_phase + phase_step;
    endfunction

    function automatic logic [31:0] random_gain_word();
        logic [15:0] g;
        case ($urandom_range(5))
            0: g = 16'd0;
            1: g = 16'd32768;
            2: g = 16'd65535;
            3: g = 16'($urandom_range(32768));
            4: g = 16'($urandom_range(65535));
            default: g = 16'd32768;
        endcase
        return {16'($urandom()), g};
    endfunction

    function automatic logic signed [15:0] random_sample();
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        return 16'($urandom());
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAX_DELAY:  max_delay = data[11:0];
            CFG_PHASE_STEP: phase_step = data[23:0];
            CFG_WET_GAIN:   wet_gain = data[15:0];
            CFG_SEND_MIX:   send_mix = data[15:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r,
                             input bit lit, input stereo_word_t lit_res);
        stereo_word_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_left_in <= l;
        s_right_in <= r;
        do @(posedge aclk); while (!s_ready);
        chorus_predict(l, r, res);
        expected_words.push_back(lit ? lit_res : res);
        words_sent++;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_output
        stereo_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got L=%0d R=%0d",
                         $time, m_left_out, m_right_out);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (want.left !== m_left_out) begin
                    $display("%0t: left mismatch, expected %0d, got %0d",
                             $time, want.left, m_left_out);
                    mismatches++;
                end
                if (want.right !== m_right_out) begin
                    $display("%0t: right mismatch, expected %0d, got %0d",
                             $time, want.right, m_right_out);
                    mismatches++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0]        t, t2, p, v;
        int                 k;
        int                 ph, seg, n;
        logic signed [15:0] l, r;

        for (int i = 0; i < SINE_SIZE; i++) begin
            k = i / (SINE_SIZE / 4);
            t = 64'((4 * i) % SINE_SIZE) * Q30_ONE / SINE_SIZE;
            if (k % 2 == 1) begin
                t = Q30_ONE - t;
            end
            t2 = (t * t) >> 30;
            p = K9;
            p = K7 - ((t2 * p) >> 30);
            p = K5 - ((t2 * p) >> 30);
            p = K3 - ((t2 * p) >> 30);
            p = K1 - ((t2 * p) >> 30);
            v = (((t * p) >> 30) + (64'd1 << 14)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            sine_tbl[i] = (k >= 2) ? -int'(v) : int'(v);
        end
        max_delay = '0;
        phase_step = '0;
        wet_gain = WET_GAIN_RESET;
        send_mix = '0;
        wr_ptr = '0;
        lfo_phase = '0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            left_line[i] = '0;
            right_line[i] = '0;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_word(dir_rows[i].left, dir_rows[i].right, dir_rows[i].lit,
                          dir_rows[i].want);
            end
        end

        for (ph = 0; ph < 3; ph++) begin
            send_gap_pct = (ph == 0) ? 37 : (ph == 1) ? 60 : 0;
            recv_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 37 : 0;
            for (seg = 0; seg < 4; seg++) begin
                wait_drained();
                case ($urandom_range(3))
                    0: write_reg(CFG_MAX_DELAY, {20'($urandom()), 12'd0});
                    1: write_reg(CFG_MAX_DELAY, {20'($urandom()), 12'd4095});
                    2: write_reg(CFG_MAX_DELAY, {20'($urandom()), 12'($urandom_range(1, 40))});
                    default: write_reg(CFG_MAX_DELAY, $urandom());
                endcase
                case ($urandom_range(3))
                    0: write_reg(CFG_PHASE_STEP, {8'($urandom()), 24'd0});
                    1: write_reg(CFG_PHASE_STEP, {8'($urandom()), 24'hFF_FFFF});
                    2: write_reg(CFG_PHASE_STEP, 32'($urandom_range(1, 5000)) << 8);
                    default: write_reg(CFG_PHASE_STEP, $urandom());
                endcase
                write_reg(CFG_WET_GAIN, random_gain_word());
                write_reg(CFG_SEND_MIX, random_gain_word());
                if (seg == 0) begin
                    write_reg(4'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), $urandom());
                end
                for (n = 0; n < SEG_WORDS; n++) begin
                    if (n == SEG_WORDS / 2) begin
                        wait_drained();
                    end
                    l = random_sample();
                    r = random_sample();
                    send_word(l, r, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);

        $display("Sent %0d stereo words, checked %0d, %0d register writes, %0d mismatches",
                 words_sent, words_checked, reg_writes, mismatches);
        $display("Covered: zero and full-line delay, gains and send above unity, masked writes");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
